// ----- hw/rtl/aspd_pkg.sv -----
`default_nettype none

package aspd_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int TOTAL_W = 32;
    localparam int CIRC_W  = 12;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = CIRC_W;

    localparam logic [CFG_ADDR_W-1:0] REG_CODE_HR    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CODE_SC    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CODE_CAD   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CODE_SPD   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CODE_PWR   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_WHEEL_CIRC = 3'd5;

    // register reset values
    localparam logic [BYTE_W-1:0] RST_CODE_HR    = 8'd120;
    localparam logic [BYTE_W-1:0] RST_CODE_SC    = 8'd121;
    localparam logic [BYTE_W-1:0] RST_CODE_CAD   = 8'd122;
    localparam logic [BYTE_W-1:0] RST_CODE_SPD   = 8'd123;
    localparam logic [BYTE_W-1:0] RST_CODE_PWR   = 8'd11;
    localparam logic [CIRC_W-1:0] RST_WHEEL_CIRC = 12'd2096;

    // power page number and its mask
    localparam logic [BYTE_W-1:0] PAGE_NUM_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] PAGE_POWER    = 8'h10;

    // divider geometry: 42-bit dividend split as hi:lo, 16-bit quotient
    localparam int Q_W   = WORD_W;
    localparam int HI_W  = 26;
    localparam int DEN_W = 21;
    localparam int CNT_W = $clog2(Q_W);

    // cadence: dr * 60 * 1024 * 16 = (dr * 15) << 16
    localparam int CAD_K_W = 20;
    // speed: dr * circ * 9 << 10, over dt * 25
    localparam int PROD_W    = WORD_W + CIRC_W;
    localparam int PROD9_W   = 32;
    localparam int SPD_SHIFT = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] device_type;
        logic [BYTE_W-1:0] page_byte0;
        logic [BYTE_W-1:0] page_byte1;
        logic [BYTE_W-1:0] page_byte2;
        logic [BYTE_W-1:0] page_byte3;
        logic [BYTE_W-1:0] page_byte4;
        logic [BYTE_W-1:0] page_byte5;
        logic [BYTE_W-1:0] page_byte6;
        logic [BYTE_W-1:0] page_byte7;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  heart_rate_bpm;
        logic [WORD_W-1:0]  cadence_rpm_x16;
        logic [WORD_W-1:0]  speed_kmh_x100;
        logic [TOTAL_W-1:0] wheel_revolutions;
        logic [BYTE_W-1:0]  power_cadence_rpm;
        logic [WORD_W-1:0]  power_watts;
    } t_out_item;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [HI_W-1:0]  hi;
        logic [Q_W-1:0]   lo;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- hw/rtl/ant_sensor_page_decoder_top.sv -----
`default_nettype none

// Sensor page decoder. Each accepted beat (device type plus eight page bytes)
// updates the sensor snapshot and yields one output beat with the whole
// snapshot. Heart-rate, power and unknown pages pass from the decode state
// to the done state, which loads the output register; cadence-only pages add
// the crank division, speed-only pages the wheel multiply and division, and
// combined speed and cadence pages both. The time is set by the bit-serial
// divider, which produces one quotient bit per cycle (16 bits per division)
// and is shared by the cadence and speed computations; a saturating result
// skips the bit steps, and a first page or a zero time delta skips the
// division. A new beat is accepted once the previous one has reached the
// output register, which holds it until taken; a result that is not taken
// stalls the next one. Configuration writes must only happen while the
// block is idle.
module ant_sensor_page_decoder_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire aspd_pkg::t_in_item                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output aspd_pkg::t_out_item                    o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [aspd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [aspd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import aspd_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DECODE     = 3'd1;
    localparam logic [2:0] S_CRANK      = 3'd2;
    localparam logic [2:0] S_CRANK_WAIT = 3'd3;
    localparam logic [2:0] S_WHEEL      = 3'd4;
    localparam logic [2:0] S_WHEEL_MUL  = 3'd5;
    localparam logic [2:0] S_WHEEL_WAIT = 3'd6;
    localparam logic [2:0] S_DONE       = 3'd7;

    // configuration registers
    logic [BYTE_W-1:0] r_code_hr, r_code_sc, r_code_cad, r_code_spd, r_code_pwr;
    logic [CIRC_W-1:0] r_circ;

    // sensor state
    logic [WORD_W-1:0]  r_last_crank_t, r_last_crank_r;
    logic [WORD_W-1:0]  r_last_wheel_t, r_last_wheel_r;
    logic               r_crank_seen, r_wheel_seen;
    logic [BYTE_W-1:0]  r_hr;
    logic [WORD_W-1:0]  r_cadence, r_speed;
    logic [TOTAL_W-1:0] r_wheel_total;
    logic [BYTE_W-1:0]  r_meter_cad;
    logic [WORD_W-1:0]  r_meter_pwr;

    // control
    logic [2:0] r_state, n_state;
    logic       r_also_wheel;
    logic       r_out_valid;

    // payload
    t_in_item          r_item;
    t_out_item         r_out;
    logic [WORD_W-1:0] r_crank_t, r_crank_r;
    logic [PROD_W-1:0] r_prod;
    logic [DEN_W-1:0]  r_wden;

    logic [WORD_W-1:0]  w_wheel_t, w_wheel_r;
    logic [WORD_W-1:0]  w_cdt, w_cdr, w_wdt, w_wdr;
    logic [CAD_K_W-1:0] w_cdr15;
    logic [PROD9_W-1:0] w_prod9;
    logic [HI_W+Q_W-1:0] w_spd_num;
    logic               w_accept;
    logic               w_out_free;
    logic               w_crank_div;
    t_div_req           w_req;
    t_div_rsp           w_rsp;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // wheel words always sit in bytes 4..7
    assign w_wheel_t = {r_item.page_byte5, r_item.page_byte4};
    assign w_wheel_r = {r_item.page_byte7, r_item.page_byte6};

    // wrapping deltas
    assign w_cdt = r_crank_t - r_last_crank_t;
    assign w_cdr = r_crank_r - r_last_crank_r;
    assign w_wdt = w_wheel_t - r_last_wheel_t;
    assign w_wdr = w_wheel_r - r_last_wheel_r;

    // cadence dividend high part: dr * 15, low part zero
    assign w_cdr15 = {w_cdr, 4'b0} - CAD_K_W'(w_cdr);
    // speed dividend: prod * 9 << 10
    assign w_prod9   = PROD9_W'({r_prod, 3'b0}) + PROD9_W'(r_prod);
    assign w_spd_num = {w_prod9, SPD_SHIFT'(0)};

    assign w_crank_div = r_crank_seen && (w_cdt != '0);

    // divider request
    always_comb begin
        w_req.start = 1'b0;
        w_req.hi    = HI_W'(w_cdr15);
        w_req.lo    = '0;
        w_req.den   = DEN_W'(w_cdt);
        if (r_state == S_CRANK) begin
            w_req.start = w_crank_div;
        end else if (r_state == S_WHEEL_MUL) begin
            w_req.start = 1'b1;
            w_req.hi    = w_spd_num[HI_W+Q_W-1:Q_W];
            w_req.lo    = w_spd_num[Q_W-1:0];
            w_req.den   = r_wden;
        end
    end

    aspd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (r_item.device_type == r_code_hr) begin
                    n_state = S_DONE;
                end else if (r_item.device_type == r_code_sc ||
                             r_item.device_type == r_code_cad) begin
                    n_state = S_CRANK;
                end else if (r_item.device_type == r_code_spd) begin
                    n_state = S_WHEEL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CRANK: begin
                if (w_crank_div) n_state = S_CRANK_WAIT;
                else if (r_also_wheel) n_state = S_WHEEL;
                else n_state = S_DONE;
            end
            S_CRANK_WAIT: begin
                if (w_rsp.done) n_state = r_also_wheel ? S_WHEEL : S_DONE;
            end
            S_WHEEL: begin
                if (r_wheel_seen && w_wdt != '0) n_state = S_WHEEL_MUL;
                else n_state = S_DONE;
            end
            S_WHEEL_MUL: begin
                n_state = S_WHEEL_WAIT;
            end
            S_WHEEL_WAIT: begin
                if (w_rsp.done) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_hr  <= RST_CODE_HR;
            r_code_sc  <= RST_CODE_SC;
            r_code_cad <= RST_CODE_CAD;
            r_code_spd <= RST_CODE_SPD;
            r_code_pwr <= RST_CODE_PWR;
            r_circ     <= RST_WHEEL_CIRC;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CODE_HR:    r_code_hr  <= i_cfg_wdata[BYTE_W-1:0];
                REG_CODE_SC:    r_code_sc  <= i_cfg_wdata[BYTE_W-1:0];
                REG_CODE_CAD:   r_code_cad <= i_cfg_wdata[BYTE_W-1:0];
                REG_CODE_SPD:   r_code_spd <= i_cfg_wdata[BYTE_W-1:0];
                REG_CODE_PWR:   r_code_pwr <= i_cfg_wdata[BYTE_W-1:0];
                REG_WHEEL_CIRC: r_circ     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // state machine, sensor state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_also_wheel   <= 1'b0;
            r_last_crank_t <= '0;
            r_last_crank_r <= '0;
            r_last_wheel_t <= '0;
            r_last_wheel_r <= '0;
            r_crank_seen   <= 1'b0;
            r_wheel_seen   <= 1'b0;
            r_hr           <= '0;
            r_cadence      <= '0;
            r_speed        <= '0;
            r_wheel_total  <= '0;
            r_meter_cad    <= '0;
            r_meter_pwr    <= '0;
        end else begin
            r_state <= n_state;
            // output valid: set on load, cleared once taken
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_DECODE: begin
                    r_also_wheel <= (r_item.device_type != r_code_hr) &&
                                    (r_item.device_type == r_code_sc);
                    if (r_item.device_type == r_code_hr) begin
                        r_hr <= r_item.page_byte7;
                    end else if (r_item.device_type != r_code_sc &&
                                 r_item.device_type != r_code_cad &&
                                 r_item.device_type != r_code_spd &&
                                 r_item.device_type == r_code_pwr &&
                                 (r_item.page_byte0 & PAGE_NUM_MASK) == PAGE_POWER) begin
                        r_meter_cad <= r_item.page_byte3;
                        r_meter_pwr <= {r_item.page_byte7, r_item.page_byte6};
                    end
                end
                S_CRANK: begin
                    r_last_crank_t <= r_crank_t;
                    r_last_crank_r <= r_crank_r;
                    r_crank_seen   <= 1'b1;
                end
                S_CRANK_WAIT: begin
                    if (w_rsp.done) r_cadence <= w_rsp.quot;
                end
                S_WHEEL: begin
                    if (r_wheel_seen) r_wheel_total <= r_wheel_total + TOTAL_W'(w_wdr);
                    r_last_wheel_t <= w_wheel_t;
                    r_last_wheel_r <= w_wheel_r;
                    r_wheel_seen   <= 1'b1;
                end
                S_WHEEL_WAIT: begin
                    if (w_rsp.done) r_speed <= w_rsp.quot;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) r_item <= i_in_data;
        if (r_state == S_DECODE) begin
            if (r_item.device_type == r_code_sc) begin
                r_crank_t <= {r_item.page_byte1, r_item.page_byte0};
                r_crank_r <= {r_item.page_byte3, r_item.page_byte2};
            end else begin
                r_crank_t <= {r_item.page_byte5, r_item.page_byte4};
                r_crank_r <= {r_item.page_byte7, r_item.page_byte6};
            end
        end
        if (r_state == S_WHEEL) begin
            r_prod <= PROD_W'(w_wdr) * PROD_W'(r_circ);
            r_wden <= DEN_W'(w_wdt) * DEN_W'(25);
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out.heart_rate_bpm    <= r_hr;
            r_out.cadence_rpm_x16   <= r_cadence;
            r_out.speed_kmh_x100    <= r_speed;
            r_out.wheel_revolutions <= r_wheel_total;
            r_out.power_cadence_rpm <= r_meter_cad;
            r_out.power_watts       <= r_meter_pwr;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DECODE))
        else $error("accepted beat not followed by decode");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_CRANK_WAIT || r_state == S_WHEEL_WAIT))
        else $error("divider result outside a wait state");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/aspd_div.sv -----
`default_nettype none

module aspd_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire aspd_pkg::t_div_req i_req,
    output aspd_pkg::t_div_rsp     o_rsp
);
    import aspd_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_sh;

    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic             w_sat;

    // one quotient bit per cycle: shift in the next dividend bit, try subtract
    assign w_trial = {r_rem, r_sh[Q_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    // quotient of 2^16 or more when the high part already reaches the divisor
    assign w_sat   = (i_req.hi >= HI_W'(i_req.den));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (w_sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(Q_W - 1);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            if (w_sat) begin
                r_sh <= '1;
            end else begin
                r_rem <= i_req.hi[DEN_W-1:0];
                r_sh  <= i_req.lo;
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
            r_sh  <= {r_sh[Q_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sh;

`ifndef NO_ASSERTIONS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("partial remainder not below divisor");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");
`endif

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// expected snapshots, one per accepted page beat, with a private copy of the
// decoder registers and sensor history
class snapshot_scoreboard;
    logic [7:0]  code_hr;
    logic [7:0]  code_sc;
    logic [7:0]  code_cad;
    logic [7:0]  code_spd;
    logic [7:0]  code_pwr;
    logic [11:0] circ_mm;

    logic [15:0] crank_t;
    logic [15:0] crank_r;
    bit          crank_valid;
    logic [15:0] wheel_t;
    logic [15:0] wheel_r;
    bit          wheel_valid;

    logic [7:0]  hr_bpm;
    logic [15:0] cad_x16;
    logic [15:0] spd_x100;
    logic [31:0] wheel_sum;
    logic [7:0]  pm_cad;
    logic [15:0] pm_watts;

    aspd_pkg::t_out_item snapshot_q[$];
    int                  errors;

    function new();
        code_hr     = aspd_pkg::RST_CODE_HR;
        code_sc     = aspd_pkg::RST_CODE_SC;
        code_cad    = aspd_pkg::RST_CODE_CAD;
        code_spd    = aspd_pkg::RST_CODE_SPD;
        code_pwr    = aspd_pkg::RST_CODE_PWR;
        circ_mm     = aspd_pkg::RST_WHEEL_CIRC;
        crank_t     = '0;
        crank_r     = '0;
        crank_valid = 1'b0;
        wheel_t     = '0;
        wheel_r     = '0;
        wheel_valid = 1'b0;
        hr_bpm      = '0;
        cad_x16     = '0;
        spd_x100    = '0;
        wheel_sum   = '0;
        pm_cad      = '0;
        pm_watts    = '0;
        errors      = 0;
    endfunction

    // register write; unknown indexes are dropped
    function void write_reg(logic [2:0] idx, logic [11:0] val);
        case (idx)
            aspd_pkg::REG_CODE_HR:    code_hr  = val[7:0];
            aspd_pkg::REG_CODE_SC:    code_sc  = val[7:0];
            aspd_pkg::REG_CODE_CAD:   code_cad = val[7:0];
            aspd_pkg::REG_CODE_SPD:   code_spd = val[7:0];
            aspd_pkg::REG_CODE_PWR:   code_pwr = val[7:0];
            aspd_pkg::REG_WHEEL_CIRC: circ_mm  = val;
            default: ;
        endcase
    endfunction

    function logic [15:0] clamp16(longint unsigned v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // crank event: cadence in rpm x16 from wrapping deltas
    function void crank_event(logic [15:0] t, logic [15:0] r);
        logic [15:0]     dt;
        logic [15:0]     dr;
        longint unsigned num;
        dt = t - crank_t;
        dr = r - crank_r;
        if (crank_valid && dt != 16'd0) begin
            // 60 s * 1024 ticks * 16 fraction steps
            num     = dr;
            num     = num * 64'd983040;
            cad_x16 = clamp16(num / dt);
        end
        crank_t     = t;
        crank_r     = r;
        crank_valid = 1'b1;
    endfunction

    // wheel event: speed in km/h x100 and running revolution total
    function void wheel_event(logic [15:0] t, logic [15:0] r);
        logic [15:0]     dt;
        logic [15:0]     dr;
        longint unsigned num;
        longint unsigned den;
        dt = t - wheel_t;
        dr = r - wheel_r;
        if (wheel_valid) begin
            if (dt != 16'd0) begin
                num      = dr;
                num      = num * circ_mm * 64'd9216;
                den      = dt;
                den      = den * 64'd25;
                spd_x100 = clamp16(num / den);
            end
            wheel_sum = wheel_sum + dr;
        end
        wheel_t     = t;
        wheel_r     = r;
        wheel_valid = 1'b1;
    endfunction

    // accepted page beat: update the snapshot and queue it
    function void note_page(aspd_pkg::t_in_item pg);
        aspd_pkg::t_out_item snap;
        if (pg.device_type == code_hr) begin
            hr_bpm = pg.page_byte7;
        end else if (pg.device_type == code_sc) begin
            crank_event({pg.page_byte1, pg.page_byte0}, {pg.page_byte3, pg.page_byte2});
            wheel_event({pg.page_byte5, pg.page_byte4}, {pg.page_byte7, pg.page_byte6});
        end else if (pg.device_type == code_cad) begin
            crank_event({pg.page_byte5, pg.page_byte4}, {pg.page_byte7, pg.page_byte6});
        end else if (pg.device_type == code_spd) begin
            wheel_event({pg.page_byte5, pg.page_byte4}, {pg.page_byte7, pg.page_byte6});
        end else if (pg.device_type == code_pwr) begin
            if ((pg.page_byte0 & aspd_pkg::PAGE_NUM_MASK) == aspd_pkg::PAGE_POWER) begin
                pm_cad   = pg.page_byte3;
                pm_watts = {pg.page_byte7, pg.page_byte6};
            end
        end
        snap.heart_rate_bpm    = hr_bpm;
        snap.cadence_rpm_x16   = cad_x16;
        snap.speed_kmh_x100    = spd_x100;
        snap.wheel_revolutions = wheel_sum;
        snap.power_cadence_rpm = pm_cad;
        snap.power_watts       = pm_watts;
        snapshot_q.push_back(snap);
    endfunction

    function bit field_ok(string name, longint unsigned want, longint unsigned got);
        if (want != got)
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        return want == got;
    endfunction

    // output beat: compare against the oldest queued snapshot
    function void check_snapshot(aspd_pkg::t_out_item got);
        aspd_pkg::t_out_item want;
        bit                  ok;
        if (snapshot_q.size() == 0) begin
            $display("%0t: output beat with nothing queued, expected none got %h",
                     $time, got);
            errors++;
            return;
        end
        want = snapshot_q.pop_front();
        ok   = 1'b1;
        ok  &= field_ok("heart_rate_bpm", want.heart_rate_bpm, got.heart_rate_bpm);
        ok  &= field_ok("cadence_rpm_x16", want.cadence_rpm_x16, got.cadence_rpm_x16);
        ok  &= field_ok("speed_kmh_x100", want.speed_kmh_x100, got.speed_kmh_x100);
        ok  &= field_ok("wheel_revolutions", want.wheel_revolutions, got.wheel_revolutions);
        ok  &= field_ok("power_cadence_rpm", want.power_cadence_rpm, got.power_cadence_rpm);
        ok  &= field_ok("power_watts", want.power_watts, got.power_watts);
        if (!ok)
            errors++;
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aspd_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 48;
    localparam int          PHASES        = 8;
    localparam int          PHASE_PAGES   = 210;
    localparam int          IDLE_PCT      = 37;

    // indexes past the register list
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum {PG_HR, PG_SC, PG_CAD, PG_SPD, PG_PWR, PG_JUNK} page_kind_e;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_data;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int unsigned        cycles = 0;
    bit                 steady;
    snapshot_scoreboard sb;

    // sensor history on the stimulus side
    logic [15:0] gen_crank_t;
    logic [15:0] gen_crank_r;
    logic [15:0] gen_wheel_t;
    logic [15:0] gen_wheel_r;

    ant_sensor_page_decoder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ant_sensor_page_decoder_top: mismatch");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // output beat check
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_snapshot(out_data);
    end

    function automatic t_in_item page_of(logic [7:0] dev, logic [15:0] w0, logic [15:0] w1,
                                         logic [15:0] w2, logic [15:0] w3);
        return {dev, w0[7:0], w0[15:8], w1[7:0], w1[15:8],
                w2[7:0], w2[15:8], w3[7:0], w3[15:8]};
    endfunction

    // event time step: mostly realistic, sometimes repeated, tiny or wild
    function automatic logic [15:0] time_step();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return 16'd0;
        if (r < 16)
            return 16'($urandom);
        if (r < 26)
            return 16'($urandom_range(40, 1));
        return 16'($urandom_range(4000, 300));
    endfunction

    function automatic logic [15:0] revs_step();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return 16'($urandom_range(3, 0));
        if (r < 88)
            return 16'($urandom_range(40, 4));
        return 16'($urandom);
    endfunction

    function automatic page_kind_e pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 14)
            return PG_HR;
        if (r < 34)
            return PG_SC;
        if (r < 50)
            return PG_CAD;
        if (r < 66)
            return PG_SPD;
        if (r < 84)
            return PG_PWR;
        return PG_JUNK;
    endfunction

    // random page of the given kind; unused bytes stay random
    function automatic t_in_item make_page(page_kind_e kind);
        t_in_item pg;
        pg = t_in_item'({$urandom, $urandom, 8'($urandom)});
        case (kind)
            PG_HR: begin
                pg.device_type = sb.code_hr;
            end
            PG_SC: begin
                gen_crank_t += time_step();
                gen_crank_r += revs_step();
                gen_wheel_t += time_step();
                gen_wheel_r += revs_step();
                pg.device_type = sb.code_sc;
                {pg.page_byte1, pg.page_byte0} = gen_crank_t;
                {pg.page_byte3, pg.page_byte2} = gen_crank_r;
                {pg.page_byte5, pg.page_byte4} = gen_wheel_t;
                {pg.page_byte7, pg.page_byte6} = gen_wheel_r;
            end
            PG_CAD: begin
                gen_crank_t += time_step();
                gen_crank_r += revs_step();
                pg.device_type = sb.code_cad;
                {pg.page_byte5, pg.page_byte4} = gen_crank_t;
                {pg.page_byte7, pg.page_byte6} = gen_crank_r;
            end
            PG_SPD: begin
                gen_wheel_t += time_step();
                gen_wheel_r += revs_step();
                pg.device_type = sb.code_spd;
                {pg.page_byte5, pg.page_byte4} = gen_wheel_t;
                {pg.page_byte7, pg.page_byte6} = gen_wheel_r;
            end
            PG_PWR: begin
                pg.device_type = sb.code_pwr;
                if ($urandom_range(99) < 75)
                    pg.page_byte0[6:0] = PAGE_POWER[6:0];
            end
            default: ;
        endcase
        return pg;
    endfunction

    // one page beat, with random idle cycles ahead of it
    task automatic send_page(t_in_item pg);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_page(pg);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stop sending and let every queued snapshot come out
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.snapshot_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register set per phase: extremes, shared codes, reset codes, then random
    task automatic configure(int ph);
        logic [7:0]  c [5];
        logic [11:0] circ;
        case (ph)
            0: begin
                c    = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128};
                circ = 12'd4095;
            end
            1: begin
                // shared codes: heart rate beats combined, cadence beats speed
                c    = '{8'd7, 8'd7, 8'd9, 8'd9, 8'd200};
                circ = 12'd0;
            end
            2: begin
                c    = '{RST_CODE_HR, RST_CODE_SC, RST_CODE_CAD, RST_CODE_SPD, RST_CODE_PWR};
                circ = 12'd1;
            end
            default: begin
                foreach (c[i])
                    c[i] = 8'($urandom);
                circ = ($urandom_range(3) == 0) ? RST_WHEEL_CIRC : 12'($urandom);
            end
        endcase
        // upper data bits must not reach the 8-bit code registers
        write_reg(REG_CODE_HR, {4'($urandom), c[0]});
        write_reg(REG_CODE_SC, {4'($urandom), c[1]});
        write_reg(REG_CODE_CAD, {4'($urandom), c[2]});
        write_reg(REG_CODE_SPD, {4'($urandom), c[3]});
        write_reg(REG_CODE_PWR, {4'($urandom), c[4]});
        write_reg(REG_WHEEL_CIRC, circ);
        write_reg(REG_SPARE_A, 12'($urandom));
        write_reg(REG_SPARE_B, 12'($urandom));
    endtask

    // directed pages under reset codes
    task automatic run_opening();
        // heart rate extremes
        send_page(page_of(RST_CODE_HR, 16'hA5A5, 16'h5A5A, 16'h0000, 16'hFF00));
        send_page(page_of(RST_CODE_HR, 16'h0000, 16'h0000, 16'h0000, 16'h00FF));
        // power: page 0x10 with toggle set, another page number, all zero
        send_page(page_of(RST_CODE_PWR, 16'h0090, 16'hFF00, 16'h0000, 16'hFFFF));
        send_page(page_of(RST_CODE_PWR, 16'hFF11, 16'h1200, 16'h0000, 16'h1234));
        send_page(page_of(RST_CODE_PWR, 16'h0010, 16'h0000, 16'h0000, 16'h0000));
        // unknown device types
        send_page(page_of(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_page(page_of(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // combined: first page only stores, second wraps time and revs
        send_page(page_of(RST_CODE_SC, 16'hFFF0, 16'hFFFE, 16'h1000, 16'h0100));
        send_page(page_of(RST_CODE_SC, 16'h03F0, 16'h0000, 16'h1400, 16'h0101));
        // cadence: zero time delta, saturation, full deltas, no revolutions
        send_page(page_of(RST_CODE_CAD, 16'h0000, 16'h0000, 16'h03F0, 16'h0005));
        send_page(page_of(RST_CODE_CAD, 16'h0000, 16'h0000, 16'h03F1, 16'h0069));
        send_page(page_of(RST_CODE_CAD, 16'h0000, 16'h0000, 16'h03F0, 16'h0068));
        send_page(page_of(RST_CODE_CAD, 16'h0000, 16'h0000, 16'h07F0, 16'h0068));
        // speed: zero time delta still adds revolutions, saturation, wrap
        send_page(page_of(RST_CODE_SPD, 16'h0000, 16'h0000, 16'h1400, 16'h0109));
        send_page(page_of(RST_CODE_SPD, 16'h0000, 16'h0000, 16'h1401, 16'h0200));
        send_page(page_of(RST_CODE_SPD, 16'h0000, 16'h0000, 16'h1000, 16'h0050));
        send_page(page_of(RST_CODE_SPD, 16'h0000, 16'h0000, 16'h1400, 16'h0051));
        send_page(page_of(RST_CODE_HR, 16'h55AA, 16'hAA55, 16'h55AA, 16'h55AA));
    endtask

    // main sequence
    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        steady      = 1'b0;
        sb          = new();
        gen_crank_t = 16'($urandom);
        gen_crank_r = 16'($urandom);
        gen_wheel_t = 16'($urandom);
        gen_wheel_r = 16'($urandom);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_opening();

        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce();
            configure(ph);
            steady = (ph == 2);
            repeat (PHASE_PAGES)
                send_page(make_page(pick_kind()));
        end
        steady = 1'b0;
        quiesce();

        if (sb.errors == 0 && sb.snapshot_q.size() == 0)
            $display("ant_sensor_page_decoder_top: match");
        else
            $display("ant_sensor_page_decoder_top: mismatch");
        $finish;
    end
endmodule
